/* hdl/assert_macros.svh */
// assertion macros shared by the frame parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is held
`define LPFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frame parser check failed");

// concurrent check that also holds across reset
`define LPFP_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("frame parser reset check failed");

`endif

/* hdl/lpfp_pkg.sv */
// shared types and constants of the length prefixed frame parser
`default_nettype none

package lpfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned KIND_W = 2;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

/* hdl/lpfp_byte_if.sv */
// valid/ready channel carrying one received byte per transfer
`default_nettype none

interface lpfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hdl/lpfp_result_if.sv */
// valid/ready channel carrying one parser result per transfer
`default_nettype none

interface lpfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [31:0] frame_length;
    logic [7:0]  value;
    logic        last;

    modport source (output valid, output kind, output command, output frame_length,
                    output value, output last, input ready);
    modport sink   (input valid, input kind, input command, input frame_length,
                    input value, input last, output ready);
endinterface

`default_nettype wire

/* hdl/lpfp_out_stage.sv */
// result register that decouples the parser from the result receiver
`default_nettype none
`include "assert_macros.svh"

module lpfp_out_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  wire lpfp_pkg::t_result i_res,
    output logic                   o_room,
    lpfp_result_if.source          o_res
);

    logic              r_valid;
    lpfp_pkg::t_result r_res;

    // room when empty or when the held result leaves this cycle
    assign o_room = !r_valid || o_res.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.command      = r_res.command;
    assign o_res.frame_length = r_res.frame_length;
    assign o_res.value        = r_res.value;
    assign o_res.last         = r_res.last;

    // loads only happen when there is room
    `LPFP_ASSERT(a_load_room, i_clk, i_rst_n, i_load |-> o_room)
    // last flag marks the check byte and nothing else
    `LPFP_ASSERT(a_last_end, i_clk, i_rst_n,
        r_valid |-> (r_res.last == (r_res.kind == lpfp_pkg::KIND_END)))
    // header results carry a zero value
    `LPFP_ASSERT(a_hdr_zero, i_clk, i_rst_n,
        (r_valid && r_res.kind == lpfp_pkg::KIND_HEADER) |-> (r_res.value == '0))

endmodule

`default_nettype wire

/* hdl/length_prefixed_frame_parser_core.sv */
// Length prefixed frame parser, top level.
// i_byte: one received byte per transfer (valid/ready). A frame is a command
//   byte, a 32-bit big-endian length, that many payload bytes, one check byte.
// o_res: one result per transfer: a header result (command and length) on
//   the fourth length byte, a data result per payload byte, and an end result
//   with last set on the check byte. Command and other length bytes give no result.
// On each byte transfer the frame state registers and the result register
//   are updated at the same edge, so a result appears on o_res in the cycle
//   after it. One byte per cycle is sustained while o_res is not stalled.
// The result register decouples the sides: a new byte is taken while a
//   result is still held, as long as that result leaves in the same cycle.
//   When the receiver stalls with a result held, i_byte.ready drops and the
//   frame state holds until the result is taken.
// Reset (synchronous, active low) empties the result register and returns
//   the parser to waiting for a command byte. A zero length frame goes from
//   the header straight to the check byte.
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_frame_parser_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    lpfp_byte_if.sink     i_byte,
    lpfp_result_if.source o_res
);

    typedef enum logic [2:0] {
        PH_CMD   = 3'd0,
        PH_LEN0  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LEN2  = 3'd3,
        PH_LEN3  = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    t_phase                          r_phase,     n_phase;
    logic [lpfp_pkg::BYTE_W-1:0]     r_command,   n_command;
    logic [lpfp_pkg::LEN_W-1:0]      r_length,    n_length;
    logic [lpfp_pkg::LEN_W-1:0]      r_remaining, n_remaining;
    logic                            room;
    logic                            xfer;
    logic                            emit;
    lpfp_pkg::t_result               res;
    logic [lpfp_pkg::LEN_W-1:0]      len_full;

    assign i_byte.ready = room;
    assign xfer         = i_byte.valid && room;

    // length with the current byte shifted in as the low byte
    assign len_full = {r_length[lpfp_pkg::LEN_W-lpfp_pkg::BYTE_W-1:0], i_byte.rx_byte};

    // next frame state and result for the incoming byte
    always_comb begin
        n_phase          = r_phase;
        n_command        = r_command;
        n_length         = r_length;
        n_remaining      = r_remaining;
        emit             = 1'b0;
        res.kind         = lpfp_pkg::KIND_HEADER;
        res.command      = r_command;
        res.frame_length = r_length;
        res.value        = '0;
        res.last         = 1'b0;
        unique case (r_phase)
            PH_LEN0: begin
                n_length = len_full;
                n_phase  = PH_LEN1;
            end
            PH_LEN1: begin
                n_length = len_full;
                n_phase  = PH_LEN2;
            end
            PH_LEN2: begin
                n_length = len_full;
                n_phase  = PH_LEN3;
            end
            PH_LEN3: begin
                n_length         = len_full;
                n_remaining      = len_full;
                n_phase          = (len_full == '0) ? PH_CHECK : PH_DATA;
                emit             = 1'b1;
                res.frame_length = len_full;
            end
            PH_DATA: begin
                emit        = 1'b1;
                res.kind    = lpfp_pkg::KIND_DATA;
                res.value   = i_byte.rx_byte;
                n_remaining = r_remaining - lpfp_pkg::LEN_W'(1);
                if (r_remaining == lpfp_pkg::LEN_W'(1)) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                emit      = 1'b1;
                res.kind  = lpfp_pkg::KIND_END;
                res.value = i_byte.rx_byte;
                res.last  = 1'b1;
                n_phase   = PH_CMD;
            end
            default: begin
                // waiting for a command byte, unused code acts the same
                n_command   = i_byte.rx_byte;
                n_length    = '0;
                n_remaining = '0;
                n_phase     = PH_LEN0;
            end
        endcase
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CMD;
            r_command   <= '0;
            r_length    <= '0;
            r_remaining <= '0;
        end else if (xfer) begin
            r_phase     <= n_phase;
            r_command   <= n_command;
            r_length    <= n_length;
            r_remaining <= n_remaining;
        end
    end

    // result register
    lpfp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (xfer && emit),
        .i_res   (res),
        .o_room  (room),
        .o_res   (o_res)
    );

    // reset returns to waiting for a command
    `LPFP_ASSERT_RST(a_rst_phase, i_clk, !i_rst_n |=> r_phase == PH_CMD)
    // payload phase always has bytes left to take
    `LPFP_ASSERT(a_data_left, i_clk, i_rst_n, (r_phase == PH_DATA) |-> (r_remaining != '0))
    // the last payload byte moves on to the check byte
    `LPFP_ASSERT(a_data_done, i_clk, i_rst_n,
        (xfer && r_phase == PH_DATA && r_remaining == lpfp_pkg::LEN_W'(1))
            |=> r_phase == PH_CHECK)
    // the check byte closes the frame
    `LPFP_ASSERT(a_check_done, i_clk, i_rst_n,
        (xfer && r_phase == PH_CHECK) |=> r_phase == PH_CMD)

endmodule

`default_nettype wire

/* tb/sv/length_prefixed_frame_parser_core_test.sv */
// self-checking testbench of the length prefixed frame parser core
`timescale 1ns / 1ps

module length_prefixed_frame_parser_core_test;

    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned FLUSH_CYCLES = 10;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned MAX_LEN_DATA = 20;

    // parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        ST_CMD     = 3'd0,
        ST_LEN3    = 3'd1,
        ST_LEN2    = 3'd2,
        ST_LEN1    = 3'd3,
        ST_LEN0    = 3'd4,
        ST_PAYLOAD = 3'd5,
        ST_CHECK   = 3'd6
    } t_parse_state;

    // one offered byte, with a hand-written expectation where it is obvious
    typedef struct {
        logic [7:0]        rx;
        bit                typed;
        bit                yields;
        lpfp_pkg::t_result res;
    } t_byte_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpfp_byte_if   byte_if ();
    lpfp_result_if res_if ();

    length_prefixed_frame_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_res   (res_if)
    );

    // predictor state
    t_parse_state parse_st   = ST_CMD;
    logic [7:0]   frame_cmd  = '0;
    logic [31:0]  frame_len  = '0;
    logic [31:0]  bytes_left = '0;

    t_byte_row         offered_bytes[$];
    lpfp_pkg::t_result pending_results[$];

    int          err_cnt       = 0;
    int unsigned sent_items    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // next parser state and the result one byte causes, if any
    function automatic bit parse_byte(input logic [7:0] b, output lpfp_pkg::t_result r);
        r = '0;
        unique case (parse_st)
            ST_LEN3: begin
                frame_len = {b, 24'h000000};
                parse_st  = ST_LEN2;
                return 1'b0;
            end
            ST_LEN2: begin
                frame_len[23:16] = b;
                parse_st = ST_LEN1;
                return 1'b0;
            end
            ST_LEN1: begin
                frame_len[15:8] = b;
                parse_st = ST_LEN0;
                return 1'b0;
            end
            ST_LEN0: begin
                frame_len[7:0] = b;
                bytes_left = frame_len;
                parse_st = (frame_len == 32'd0) ? ST_CHECK : ST_PAYLOAD;
                r = '{kind: lpfp_pkg::KIND_HEADER, command: frame_cmd,
                      frame_length: frame_len, value: 8'h00, last: 1'b0};
                return 1'b1;
            end
            ST_PAYLOAD: begin
                r = '{kind: lpfp_pkg::KIND_DATA, command: frame_cmd,
                      frame_length: frame_len, value: b, last: 1'b0};
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0) begin
                    parse_st = ST_CHECK;
                end
                return 1'b1;
            end
            ST_CHECK: begin
                r = '{kind: lpfp_pkg::KIND_END, command: frame_cmd,
                      frame_length: frame_len, value: b, last: 1'b1};
                parse_st = ST_CMD;
                return 1'b1;
            end
            default: begin
                frame_cmd  = b;
                frame_len  = '0;
                bytes_left = '0;
                parse_st   = ST_LEN3;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic t_byte_row predicted_row(input logic [7:0] b);
        t_byte_row row;
        row.rx     = b;
        row.typed  = 1'b0;
        row.yields = 1'b0;
        row.res    = '0;
        return row;
    endfunction

    function automatic t_byte_row typed_row(input logic [7:0] b, input bit yields,
                                            input lpfp_pkg::t_kind kind,
                                            input logic [7:0] cmd,
                                            input logic [31:0] len, input logic [7:0] val,
                                            input logic last);
        t_byte_row row;
        row.rx     = b;
        row.typed  = 1'b1;
        row.yields = yields;
        row.res    = '{kind: kind, command: cmd, frame_length: len, value: val, last: last};
        return row;
    endfunction

    // offer one byte, with a random gap first, and hold it until the transfer
    task automatic send_row(input t_byte_row row);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.rx_byte <= row.rx;
        offered_bytes.push_back(row);
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        sent_items++;
    endtask

    // one frame with random payload; the check byte is sent only when data_cnt equals len
    task automatic send_frame(input logic [7:0] cmd, input logic [31:0] len,
                              input int unsigned data_cnt);
        send_row(predicted_row(cmd));
        send_row(predicted_row(len[31:24]));
        send_row(predicted_row(len[23:16]));
        send_row(predicted_row(len[15:8]));
        send_row(predicted_row(len[7:0]));
        for (int unsigned i = 0; i < data_cnt; i++) begin
            send_row(predicted_row(8'($urandom)));
        end
        if (data_cnt == len) begin
            send_row(predicted_row(8'($urandom)));
        end
    endtask

    // hold the sender off until every expected result has arrived
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || offered_bytes.size() != 0) @(posedge i_clk);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // scoreboard, predictor update and watchdog
    always @(posedge i_clk) begin : scoreboard
        lpfp_pkg::t_result exp_res;
        lpfp_pkg::t_result got_res;
        t_byte_row         row;
        bit                has_res;
        bit                moved;

        moved = 1'b0;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d value %h",
                       res_if.kind, res_if.value);
                err_cnt++;
            end else begin
                exp_res = pending_results.pop_front();
                if (res_if.kind !== exp_res.kind) begin
                    $error("kind: expected %0d, got %0d", exp_res.kind, res_if.kind);
                    err_cnt++;
                end
                if (res_if.command !== exp_res.command) begin
                    $error("command: expected %h, got %h", exp_res.command, res_if.command);
                    err_cnt++;
                end
                if (res_if.frame_length !== exp_res.frame_length) begin
                    $error("frame_length: expected %h, got %h",
                           exp_res.frame_length, res_if.frame_length);
                    err_cnt++;
                end
                if (res_if.value !== exp_res.value) begin
                    $error("value: expected %h, got %h", exp_res.value, res_if.value);
                    err_cnt++;
                end
                if (res_if.last !== exp_res.last) begin
                    $error("last: expected %0d, got %0d", exp_res.last, res_if.last);
                    err_cnt++;
                end
            end
        end
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            moved   = 1'b1;
            row     = offered_bytes.pop_front();
            has_res = parse_byte(byte_if.rx_byte, got_res);
            if (row.typed) begin
                if (row.yields) begin
                    pending_results.push_back(row.res);
                end
            end else if (has_res) begin
                pending_results.push_back(got_res);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("length_prefixed_frame_parser_core_test: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_byte_row   directed[$];
        logic [31:0] len;
        int unsigned pick;
        int unsigned stage_end;

        byte_if.valid   <= 1'b0;
        byte_if.rx_byte <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length frame: header, then the check byte straight away
        directed.push_back(typed_row(8'hFF, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b1, lpfp_pkg::KIND_HEADER, 8'hFF, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b1, lpfp_pkg::KIND_END, 8'hFF, 32'd0,
                                     8'h00, 1'b1));
        // three payload bytes, two of them at the byte extremes
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h00, 1'b0, lpfp_pkg::KIND_HEADER, 8'h00, 32'd0,
                                     8'h00, 1'b0));
        directed.push_back(typed_row(8'h03, 1'b1, lpfp_pkg::KIND_HEADER, 8'h00, 32'd3,
                                     8'h00, 1'b0));
        directed.push_back(predicted_row(8'hFF));
        directed.push_back(predicted_row(8'h00));
        directed.push_back(predicted_row(8'h5A));
        directed.push_back(typed_row(8'hFF, 1'b1, lpfp_pkg::KIND_END, 8'h00, 32'd3,
                                     8'hFF, 1'b1));
        // single payload byte
        directed.push_back(predicted_row(8'h3C));
        directed.push_back(predicted_row(8'h00));
        directed.push_back(predicted_row(8'h00));
        directed.push_back(predicted_row(8'h00));
        directed.push_back(predicted_row(8'h01));
        directed.push_back(predicted_row(8'h80));
        directed.push_back(predicted_row(8'h7F));
        foreach (directed[i]) begin
            send_row(directed[i]);
        end

        // random frames, in three stages of idling
        sent_items = 0;
        for (int stage = 0; stage < 3; stage++) begin
            wait_drained();
            src_idle_pct  = (stage == 0) ? 18 : (stage == 1) ? 86 : 0;
            sink_idle_pct = (stage == 0) ? 86 : (stage == 1) ? 18 : 0;
            stage_end = (RANDOM_ITEMS * (stage + 1)) / 3;
            while (sent_items < stage_end) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    len = $urandom_range(6);
                end else if (pick < 95) begin
                    len = $urandom_range(40, 7);
                end else begin
                    len = $urandom_range(300, 100);
                end
                send_frame(8'($urandom), len, len);
            end
        end

        // largest length: header, then a run of payload bytes that never ends the frame
        send_frame(8'hA5, 32'hFFFF_FFFF, MAX_LEN_DATA);

        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || offered_bytes.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("length_prefixed_frame_parser_core_test: clean");
        end else begin
            $display("length_prefixed_frame_parser_core_test: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/lpfp_pkg.sv
hdl/lpfp_byte_if.sv
hdl/lpfp_result_if.sv
hdl/lpfp_out_stage.sv
hdl/length_prefixed_frame_parser_core.sv
tb/sv/length_prefixed_frame_parser_core_test.sv
